// ===== src/assert_macros.svh =====
// assertion macros shared by the checker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ===== src/ufcc_pkg.sv =====
// types, constants and crc function of the update frame checker
`default_nettype none

package ufcc_pkg;

  localparam int PAYLOAD_MAX_DEFAULT = 1024;

  localparam logic [7:0]  HEADER_RESET = 8'hFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  // frame layout: sync bytes, then address, then length
  localparam int SYNC_BYTES = 4;
  localparam int ADDR_END   = 8;
  localparam int HEAD_BYTES = 10;

  localparam int COUNT_W     = 17;
  localparam int QUEUE_DEPTH = 4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT      = 3'd1;
  localparam logic [2:0] ST_HEADER_BAD = 3'd2;
  localparam logic [2:0] ST_TOO_LONG   = 3'd3;
  localparam logic [2:0] ST_CRC_BAD    = 3'd4;
  localparam logic [2:0] ST_INCOMPLETE = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HEAD = 3'd1,
    PH_DATA = 3'd2,
    PH_CRCH = 3'd3,
    PH_CRCL = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_start;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_status;
    logic [31:0] frame_address;
    logic [15:0] payload_length;
    logic        last_of_run;
  } out_item_t;

  // results written to the queue by one transaction
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  // crc-16/arc update by one byte, lsb first
  function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc,
                                                 input logic [7:0]  data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/ufcc_parser.sv =====
// frame parser: field capture, crc update and result generation per byte
`default_nettype none
`include "assert_macros.svh"

module ufcc_parser #(
  parameter int PAYLOAD_MAX = ufcc_pkg::PAYLOAD_MAX_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire ufcc_pkg::in_item_t  in_item,
  input  wire logic [7:0]          header_value,
  output ufcc_pkg::push_t          push,
  output ufcc_pkg::out_item_t      res0,
  output ufcc_pkg::out_item_t      res1
);
  import ufcc_pkg::*;

  localparam logic [15:0] MAX_LEN = 16'(PAYLOAD_MAX);

  phase_t               phase, phase_cur, phase_next;
  logic [COUNT_W-1:0]   byte_count, count_cur, byte_count_next;
  logic [15:0]          crc_accum, crc_cur, crc_accum_next;
  logic [31:0]          address_reg, addr_cur, address_reg_next;
  logic [15:0]          length_reg, len_cur, length_reg_next;
  logic                 header_bad, hbad_cur, header_bad_next;
  logic [7:0]           crc_high_rx, crch_cur, crc_high_rx_next;

  logic      prim_vld;
  logic      idle_byte;
  logic      end_vld;
  out_item_t prim;
  out_item_t end_item;

  always_comb begin
    // buffer start restarts the frame with this byte
    if (in_item.buffer_start) begin
      phase_cur = PH_HEAD;
      count_cur = '0;
      crc_cur   = '0;
      addr_cur  = '0;
      len_cur   = '0;
      hbad_cur  = 1'b0;
      crch_cur  = '0;
    end else begin
      phase_cur = phase;
      count_cur = byte_count;
      crc_cur   = crc_accum;
      addr_cur  = address_reg;
      len_cur   = length_reg;
      hbad_cur  = header_bad;
      crch_cur  = crc_high_rx;
    end

    phase_next       = phase_cur;
    byte_count_next  = count_cur;
    crc_accum_next   = crc_cur;
    address_reg_next = addr_cur;
    length_reg_next  = len_cur;
    header_bad_next  = hbad_cur;
    crc_high_rx_next = crch_cur;

    prim_vld  = 1'b0;
    idle_byte = 1'b0;
    prim      = '0;

    unique case (phase_cur)
      PH_HEAD: begin
        crc_accum_next = crc16_arc_byte(crc_cur, in_item.rx_byte);
        if (count_cur < COUNT_W'(SYNC_BYTES)) begin
          if (in_item.rx_byte != header_value) begin
            header_bad_next = 1'b1;
          end
        end else if (count_cur < COUNT_W'(ADDR_END)) begin
          address_reg_next = {addr_cur[23:0], in_item.rx_byte};
        end else begin
          length_reg_next = {len_cur[7:0], in_item.rx_byte};
        end
        byte_count_next = count_cur + 1'b1;
        if (byte_count_next == COUNT_W'(HEAD_BYTES)) begin
          if (header_bad_next) begin
            prim_vld          = 1'b1;
            prim.item_kind    = KIND_STATUS;
            prim.frame_status = ST_HEADER_BAD;
            phase_next        = PH_IDLE;
          end else if (length_reg_next > MAX_LEN) begin
            prim_vld          = 1'b1;
            prim.item_kind    = KIND_STATUS;
            prim.frame_status = ST_TOO_LONG;
            phase_next        = PH_IDLE;
          end else if (length_reg_next == '0) begin
            phase_next = PH_CRCH;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        crc_accum_next    = crc16_arc_byte(crc_cur, in_item.rx_byte);
        prim_vld          = 1'b1;
        prim.item_kind    = KIND_PAYLOAD;
        prim.payload_byte = in_item.rx_byte;
        byte_count_next   = count_cur + 1'b1;
        if (byte_count_next >= COUNT_W'(HEAD_BYTES) + COUNT_W'(len_cur)) begin
          phase_next = PH_CRCH;
        end
      end
      PH_CRCH: begin
        crc_high_rx_next = in_item.rx_byte;
        byte_count_next  = count_cur + 1'b1;
        phase_next       = PH_CRCL;
      end
      PH_CRCL: begin
        byte_count_next = count_cur + 1'b1;
        prim_vld        = 1'b1;
        prim.item_kind  = KIND_STATUS;
        if (crch_cur == crc_cur[15:8] && in_item.rx_byte == crc_cur[7:0]) begin
          prim.frame_status = ST_OK;
        end else begin
          prim.frame_status = ST_CRC_BAD;
        end
        phase_next = PH_IDLE;
      end
      default: begin
        // stray byte outside a frame
        idle_byte  = 1'b1;
        phase_next = PH_IDLE;
      end
    endcase

    prim.frame_address  = address_reg_next;
    prim.payload_length = length_reg_next;

    // buffer ended on an unfinished frame
    end_vld = in_item.buffer_end && !idle_byte && (phase_next != PH_IDLE);
    if (end_vld) begin
      phase_next = PH_IDLE;
    end

    end_item           = '0;
    end_item.item_kind = KIND_STATUS;
    if (byte_count_next < COUNT_W'(HEAD_BYTES)) begin
      end_item.frame_status = ST_SHORT;
    end else begin
      end_item.frame_status   = ST_INCOMPLETE;
      end_item.frame_address  = address_reg_next;
      end_item.payload_length = length_reg_next;
    end

    if (prim_vld) begin
      res0        = prim;
      res1        = end_item;
      push.first  = accept;
      push.second = accept && end_vld;
    end else begin
      res0        = end_item;
      res1        = end_item;
      push.first  = accept && end_vld;
      push.second = 1'b0;
    end
    res0.last_of_run = !(prim_vld && end_vld);
    res1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      byte_count  <= '0;
      crc_accum   <= '0;
      address_reg <= '0;
      length_reg  <= '0;
      header_bad  <= 1'b0;
      crc_high_rx <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      crc_accum   <= crc_accum_next;
      address_reg <= address_reg_next;
      length_reg  <= length_reg_next;
      header_bad  <= header_bad_next;
      crc_high_rx <= crc_high_rx_next;
    end
  end

  `ASSERT_CLK(a_second_after_payload, clk, rst,
              push.second |-> (push.first && res0.item_kind == KIND_PAYLOAD),
              "second result without a payload result ahead of it")
  `ASSERT_CLK(a_last_flag, clk, rst,
              push.first |-> (res0.last_of_run != push.second),
              "last_of_run misplaced in a two-result transaction")
  `ASSERT_CLK(a_start_restarts, clk, rst,
              (accept && in_item.buffer_start && !in_item.buffer_end)
              |=> (phase == PH_HEAD && byte_count == COUNT_W'(1)),
              "buffer start did not restart the header")

endmodule

`default_nettype wire

// ===== src/ufcc_result_queue.sv =====
// small result queue taking up to two results per cycle, one out per cycle while out_stall is low
`default_nettype none
`include "assert_macros.svh"

module ufcc_result_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ufcc_pkg::push_t      push,
  input  wire ufcc_pkg::out_item_t  res0,
  input  wire ufcc_pkg::out_item_t  res1,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ufcc_pkg::out_item_t       out_data
);
  import ufcc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  out_item_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W:0]   fill_sum;
  logic             pop;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // two free slots needed for a transaction that may bring two results
  assign room      = (count <= CNT_W'(QUEUE_DEPTH - 2));

  assign fill_sum   = (CNT_W + 1)'(count) + (CNT_W + 1)'(push.first)
                    + (CNT_W + 1)'(push.second);
  assign count_next = CNT_W'(fill_sum - (CNT_W + 1)'(pop));

  always_ff @(posedge clk) begin
    if (push.first) begin
      entries[wr_ptr] <= res0;
    end
    if (push.second) begin
      entries[PTR_W'(wr_ptr + 1'b1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_W'(wr_ptr + PTR_W'(push.first) + PTR_W'(push.second));
      if (pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      count <= count_next;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst,
                fill_sum > (CNT_W + 1)'(QUEUE_DEPTH),
                "result queue overflow")
  `ASSERT_CLK(a_ptr_match, clk, rst,
              PTR_W'(wr_ptr - rd_ptr) == count[PTR_W-1:0],
              "queue pointers disagree with fill count")
  `ASSERT_CLK(a_push_order, clk, rst,
              push.second |-> push.first,
              "second result pushed without the first")

endmodule

`default_nettype wire

// ===== src/update_frame_crc_checker.sv =====
// top level of the update frame checker with crc-16/arc
`default_nettype none

// Receives an update frame one byte per transaction: four sync bytes that must
// all equal header_value, a big-endian 32-bit address, a big-endian 16-bit
// payload length, the payload and a crc-16/arc (init 0, reflected 0xA001) over
// header and payload, high byte first. Each payload byte is passed out as it
// arrives; every frame closes with one status transaction (ok, short, header
// bad, too long, crc bad, incomplete). buffer_start restarts parsing at that
// byte; bytes outside a frame produce nothing. One input byte is taken per
// cycle while in_stall is low: the parser handles a byte combinationally, crc
// included, and writes its results into a four-entry result queue, which
// registers them for the output. A byte can bring two results (a payload byte
// followed by an incomplete status at buffer end); the output moves one result
// per cycle while out_stall is low, and in_stall rises while the queue has
// fewer than two free slots. header_value resets to 0xFF and is written through
// cfg, which is always ready; write it only while no frame is in flight.
module update_frame_crc_checker #(
  parameter int PAYLOAD_MAX = ufcc_pkg::PAYLOAD_MAX_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // byte stream in
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ufcc_pkg::in_item_t   in_data,
  // results out
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ufcc_pkg::out_item_t       out_data,
  // header value register write
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [7:0]           cfg_data
);
  import ufcc_pkg::*;

  logic [7:0] header_byte;
  logic       accept;
  logic       room;
  push_t      push;
  out_item_t  res0;
  out_item_t  res1;

  // configuration register, writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      header_byte <= cfg_data;
    end
  end

  // a byte transaction completes when valid and the queue has room
  assign in_stall     = !room;
  assign accept       = in_valid && !in_stall;

  ufcc_parser #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_item      (in_data),
    .header_value (header_byte),
    .push         (push),
    .res0         (res0),
    .res1         (res1)
  );

  ufcc_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
